[rtl/ssd_pkg.sv]
// Shared types, constants and lookup functions for the seven-segment scan driver.
// No dependencies; imported by ssd_bcd_pipe and seven_segment_scan_driver.
`default_nettype none

package ssd_pkg;

  // Display geometry and scan timing
  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned PWM_STEPS  = 10;   // steps per digit period, 2..15

  // Saturation limit for loaded numbers
  localparam logic [13:0] MAX_SHOWN   = 14'd9999;
  localparam logic [3:0]  BRIGHT_RST  = 4'd10;
  localparam logic [7:0]  BLANK_GLYPH = 8'hFF;

  // Reciprocal constants for divide-by-constant
  localparam logic [13:0] RECIP_1000 = 14'd8389;   // floor(v*8389 >> 23), v < 10000
  localparam logic [13:0] RECIP_100  = 14'd10486;  // floor(r*10486 >> 20), r < 1000
  localparam logic [7:0]  RECIP_10   = 8'd205;     // floor(r*205 >> 11), r < 1029

  typedef logic [3:0] digit_t;

  // One item as it leaves the conversion pipeline
  typedef struct packed {
    logic                        load;
    digit_t [NUM_DIGITS-1:0]     digits;   // entry 0 = thousands
  } ssd_item_t;

  // Active-low font, bits DP G F E D C B A
  function automatic logic [7:0] glyph(input digit_t d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = BLANK_GLYPH;
    endcase
    return g;
  endfunction

  // Digit times 1000
  function automatic logic [13:0] thousands_val(input digit_t d);
    logic [13:0] v;
    case (d)
      4'd1:    v = 14'd1000;
      4'd2:    v = 14'd2000;
      4'd3:    v = 14'd3000;
      4'd4:    v = 14'd4000;
      4'd5:    v = 14'd5000;
      4'd6:    v = 14'd6000;
      4'd7:    v = 14'd7000;
      4'd8:    v = 14'd8000;
      4'd9:    v = 14'd9000;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  // Digit times 100
  function automatic logic [9:0] hundreds_val(input digit_t d);
    logic [9:0] v;
    case (d)
      4'd1:    v = 10'd100;
      4'd2:    v = 10'd200;
      4'd3:    v = 10'd300;
      4'd4:    v = 10'd400;
      4'd5:    v = 10'd500;
      4'd6:    v = 10'd600;
      4'd7:    v = 10'd700;
      4'd8:    v = 10'd800;
      4'd9:    v = 10'd900;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/ssd_bcd_pipe.sv]
// Four-stage pipeline: input capture with saturation, then binary to decimal digits.
// Ticks ride along unchanged so item order is kept. Depends on ssd_pkg.
`default_nettype none

module ssd_bcd_pipe
  import ssd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_load,
  input  wire logic [15:0] in_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output ssd_item_t        out_item
);

  // Per-stage valid and bubble-collapsing ready chain
  logic v0, v1, v2, v3;
  logic r0, r1, r2, r3;

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign r0 = !v1 || r1 ? !v0 || r1 : !v0;
  assign in_ready = r0;

  // Stage 0: captured item, number saturated
  logic        ld0;
  logic [13:0] val0;
  logic [13:0] sat_val;
  assign sat_val = (in_number > 16'(MAX_SHOWN)) ? MAX_SHOWN : in_number[13:0];

  // Stage 1: thousands digit
  logic        ld1;
  logic [13:0] val1;
  digit_t      th1;
  logic [27:0] prod_th;
  assign prod_th = 28'(val0) * 28'(RECIP_1000);

  // Stage 2: hundreds digit
  logic        ld2;
  digit_t      th2, hu2;
  logic [9:0]  rem2;
  logic [9:0]  rem_th;
  logic [13:0] diff_th;
  logic [23:0] prod_hu;
  assign diff_th = val1 - thousands_val(th1);
  assign rem_th  = diff_th[9:0];
  assign prod_hu = 24'(rem_th) * 24'(RECIP_100);

  // Stage 3: tens and ones
  logic        ld3;
  digit_t      th3, hu3, te3, on3;
  logic [9:0]  diff_hu;
  logic [6:0]  rem_hu;
  logic [14:0] prod_te;
  digit_t      te_calc;
  logic [6:0]  ones_full;
  assign diff_hu   = rem2 - hundreds_val(hu2);
  assign rem_hu    = diff_hu[6:0];
  assign prod_te   = 15'(rem_hu) * 15'(RECIP_10);
  assign te_calc   = prod_te[14:11];
  assign ones_full = rem_hu - {te_calc, 3'b000} - {2'b00, te_calc, 1'b0};

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r0) v0 <= in_valid;
      if (r1) v1 <= v0;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (r0) begin
      ld0  <= in_load;
      val0 <= sat_val;
    end
    if (r1) begin
      ld1  <= ld0;
      val1 <= val0;
      th1  <= prod_th[26:23];
    end
    if (r2) begin
      ld2  <= ld1;
      th2  <= th1;
      hu2  <= prod_hu[23:20];
      rem2 <= rem_th;
    end
    if (r3) begin
      ld3 <= ld2;
      th3 <= th2;
      hu3 <= hu2;
      te3 <= te_calc;
      on3 <= ones_full[3:0];
    end
  end

  assign out_valid        = v3;
  assign out_item.load    = ld3;
  assign out_item.digits  = {on3, te3, hu3, th3};

endmodule

`default_nettype wire

[rtl/seven_segment_scan_driver.sv]
// A tick goes through the ssd_bcd_pipe stages and then the output register; loads give none.
// Throughput: one beat per cycle through pipeline and scan stage unless the output stalls.
// A result waiting at the output stalls only the last stage; earlier stages keep filling.
// Reset: brightness 10, all digits nine, scan and PWM step zero, segments all off.
// Top level of the seven-segment scan driver; depends on ssd_pkg and ssd_bcd_pipe.
`default_nettype none

module seven_segment_scan_driver
  import ssd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] number
  input  wire logic [0:0]  s_tuser,   // [0] mode: 0 tick, 1 load
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] segments, [11:8] digit_enable, [15:12] zero
  // Brightness register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  // Conversion pipeline
  logic      it_valid, it_ready;
  ssd_item_t item;

  ssd_bcd_pipe u_bcd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_load   (s_tuser[0]),
    .in_number (s_tdata),
    .out_valid (it_valid),
    .out_ready (it_ready),
    .out_item  (item)
  );

  // Scan state
  logic [3:0]                  brightness;
  digit_t [NUM_DIGITS-1:0]     digit_store;
  logic [1:0]                  scan_position;
  logic [3:0]                  pwm_step;
  logic [7:0]                  held_segments;
  logic [3:0]                  enable_q;

  // Loads never need the output register
  logic fire;
  assign it_ready  = item.load || !m_tvalid || m_tready;
  assign fire      = it_valid && it_ready;
  assign cfg_ready = 1'b1;

  // Tick step: advance PWM, wrap moves scan, lit while below brightness
  logic [3:0] step_inc, pwm_step_next;
  logic       wrap, lit;
  logic [1:0] scan_position_next;
  logic [7:0] held_segments_next;
  logic [3:0] enable_next;

  always_comb begin
    step_inc           = pwm_step + 4'd1;
    wrap               = (step_inc >= 4'(PWM_STEPS));
    pwm_step_next      = wrap ? 4'd0 : step_inc;
    scan_position_next = wrap ? scan_position + 2'd1 : scan_position;
    lit                = (pwm_step_next < brightness);
    held_segments_next = lit ? glyph(digit_store[scan_position_next]) : held_segments;
    enable_next        = lit ? (4'b0001 << scan_position_next) : 4'b0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= BRIGHT_RST;
      digit_store   <= {NUM_DIGITS{4'd9}};
      scan_position <= 2'd0;
      pwm_step      <= 4'd0;
      held_segments <= BLANK_GLYPH;
      enable_q      <= 4'b0000;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) brightness <= cfg_data;
      if (fire && item.load) begin
        digit_store <= item.digits;
      end
      if (fire && !item.load) begin
        pwm_step      <= pwm_step_next;
        scan_position <= scan_position_next;
        held_segments <= held_segments_next;
        enable_q      <= enable_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {4'b0000, enable_q, held_segments};

  // Checks
  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(enable_q))
    else $error("digit enable not one-hot");

  a_enable_scan: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && enable_q != 4'b0000) |-> (enable_q == (4'b0001 << scan_position)))
    else $error("digit enable does not match scan position");

  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    pwm_step < 4'(PWM_STEPS))
    else $error("PWM step out of range");

  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    (digit_store[0] <= 4'd9) && (digit_store[1] <= 4'd9) &&
    (digit_store[2] <= 4'd9) && (digit_store[3] <= 4'd9))
    else $error("stored digit above nine");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(held_segments) && $stable(enable_q))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
